[hw/rtl/pgp_packet_header_parser_core_defines.svh]
// assertion macros for the header parser rtl
`ifndef PGP_PACKET_HEADER_PARSER_CORE_DEFINES_SVH
`define PGP_PACKET_HEADER_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PHDR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PHDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/phdr_pkg.sv]
// types and constants of the packet header parser
`default_nettype none
package phdr_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;
	localparam int LEN_W      = 32;
	localparam int TYPE_W     = 6;

	// new-format length octet codes
	localparam int          NEW_ONE_MAX   = 192;
	localparam int          NEW_TWO_BASE  = 192;
	localparam logic [7:0]  TWO_OCT_MASK  = 8'hE0;
	localparam logic [7:0]  TWO_OCT_CODE  = 8'hC0;
	localparam logic [7:0]  FIVE_OCT_CODE = 8'hFF;
	localparam logic [1:0]  TAG_OLD       = 2'b10;
	localparam logic [1:0]  TAG_NEW       = 2'b11;
	localparam logic [1:0]  LL_INDET      = 2'b11;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_OLD_LEN,
		PH_NEW_FIRST,
		PH_NEW_SECOND,
		PH_NEW_FIVE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_END,
		ST_TRUNC,
		ST_NOT_HDR
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [TYPE_W-1:0]   packet_type;
		logic [LEN_W-1:0]    packet_length;
		logic                length_known;
		logic                partial;
		logic                new_format;
	} res_t;

endpackage
`default_nettype wire

[hw/rtl/phdr_fsm.sv]
// header state machine: state registers and per-word next-state logic
`default_nettype none
module phdr_fsm
	import phdr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [IN_DATA_W-1:0] data_byte,
	input  wire logic                 stream_end,
	output logic                      emit,
	output res_t                      res
);

	phase_t             phase_q, phase_d;
	logic [TYPE_W-1:0]  type_hold_q, type_hold_d;
	logic [LEN_W-1:0]   length_accum_q, length_accum_d;
	logic [2:0]         bytes_left_q, bytes_left_d;
	logic               format_hold_q, format_hold_d;
	logic [4:0]         first_len_q, first_len_d;

	logic [LEN_W-1:0]   acc_shift;
	logic [2:0]         left_dec;
	logic [13:0]        two_oct_len;

	assign acc_shift   = {length_accum_q[LEN_W-9:0], data_byte};
	assign left_dec    = bytes_left_q - 3'd1;
	assign two_oct_len = {1'b0, first_len_q, data_byte} + 14'(NEW_TWO_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			type_hold_q    <= '0;
			length_accum_q <= '0;
			bytes_left_q   <= '0;
			format_hold_q  <= 1'b0;
			first_len_q    <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			type_hold_q    <= type_hold_d;
			length_accum_q <= length_accum_d;
			bytes_left_q   <= bytes_left_d;
			format_hold_q  <= format_hold_d;
			first_len_q    <= first_len_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		type_hold_d    = type_hold_q;
		length_accum_d = length_accum_q;
		bytes_left_d   = bytes_left_q;
		format_hold_d  = format_hold_q;
		first_len_d    = first_len_q;
		emit           = 1'b0;
		res            = '0;

		if (stream_end) begin
			emit       = 1'b1;
			res.status = (phase_q == PH_IDLE) ? ST_END : ST_TRUNC;
			phase_d    = PH_IDLE;
		end else begin
			case (phase_q)
				PH_OLD_LEN, PH_NEW_FIVE: begin
					length_accum_d = acc_shift;
					bytes_left_d   = left_dec;
					if (left_dec == 3'd0) begin
						emit              = 1'b1;
						res.status        = ST_OK;
						res.packet_type   = type_hold_q;
						res.packet_length = acc_shift;
						res.length_known  = 1'b1;
						res.new_format    = format_hold_q;
						phase_d           = PH_IDLE;
					end
				end
				PH_NEW_FIRST: begin
					if (data_byte < 8'(NEW_ONE_MAX)) begin
						emit              = 1'b1;
						res.status        = ST_OK;
						res.packet_type   = type_hold_q;
						res.packet_length = LEN_W'(data_byte);
						res.length_known  = 1'b1;
						res.new_format    = 1'b1;
						phase_d           = PH_IDLE;
					end else if ((data_byte & TWO_OCT_MASK) == TWO_OCT_CODE) begin
						first_len_d = data_byte[4:0];
						phase_d     = PH_NEW_SECOND;
					end else if (data_byte == FIVE_OCT_CODE) begin
						length_accum_d = '0;
						bytes_left_d   = 3'd4;
						phase_d        = PH_NEW_FIVE;
					end else begin
						// partial body: chunk of 2^n bytes
						emit              = 1'b1;
						res.status        = ST_OK;
						res.packet_type   = type_hold_q;
						res.packet_length = 32'd1 << data_byte[4:0];
						res.length_known  = 1'b1;
						res.partial       = 1'b1;
						res.new_format    = 1'b1;
						phase_d           = PH_IDLE;
					end
				end
				PH_NEW_SECOND: begin
					emit              = 1'b1;
					res.status        = ST_OK;
					res.packet_type   = type_hold_q;
					res.packet_length = LEN_W'(two_oct_len);
					res.length_known  = 1'b1;
					res.new_format    = 1'b1;
					phase_d           = PH_IDLE;
				end
				default: begin
					// idle: every word is taken as a tag
					if (data_byte[7:6] == TAG_OLD) begin
						type_hold_d   = TYPE_W'(data_byte[5:2]);
						format_hold_d = 1'b0;
						if (data_byte[1:0] == LL_INDET) begin
							emit            = 1'b1;
							res.status      = ST_OK;
							res.packet_type = TYPE_W'(data_byte[5:2]);
							phase_d         = PH_IDLE;
						end else begin
							length_accum_d = '0;
							bytes_left_d   = 3'd1 << data_byte[1:0];
							phase_d        = PH_OLD_LEN;
						end
					end else if (data_byte[7:6] == TAG_NEW) begin
						type_hold_d   = data_byte[5:0];
						format_hold_d = 1'b1;
						phase_d       = PH_NEW_FIRST;
					end else begin
						emit       = 1'b1;
						res.status = ST_NOT_HDR;
						phase_d    = PH_IDLE;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/phdr_out_reg.sv]
// result register on the master side
`default_nettype none
module phdr_out_reg
	import phdr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t res_in,
	input  wire logic pop,
	output logic      free,
	output logic      valid_q,
	output res_t      res_q
);

	assign free = !valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			res_q <= res_in;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/pgp_packet_header_parser_core.sv]
// packet header parser top level: input register, state machine, result register
//
//  channel  dir  payload                                 handshake
//  s_*      in   tdata: data_byte, tuser: stream_end     tvalid/tready
//  m_*      out  tdata: type,length,flags; tuser: status tvalid/tready
//
// one word per cycle sustained while the master side takes results; each word
// passes through the input register, where the state machine updates, and the
// header result is registered in the result register as the word leaves it.
// reset clears the state machine to idle and both registers to empty.
// a stalled master side holds an emitting word in the input register;
// words that emit nothing keep flowing.
`default_nettype none
`include "pgp_packet_header_parser_core_defines.svh"
module pgp_packet_header_parser_core
	import phdr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
	input  wire logic                  s_tuser,   // [0] stream_end
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // [5:0] packet_type, [37:6] packet_length,
	                                              // [38] length_known, [39] partial,
	                                              // [40] new_format, [47:41] zero
	output logic [1:0]                 m_tuser    // [1:0] status
);

	logic                 valid_s1;
	logic [IN_DATA_W-1:0] byte_s1;
	logic                 end_s1;
	logic                 emit;
	logic                 out_free;
	logic                 advance;
	res_t                 res;
	res_t                 res_q;

	// a word leaves the input register unless its result is blocked
	assign advance  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tuser;
		end
	end

	phdr_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.stream_end (end_s1),
		.emit       (emit),
		.res        (res)
	);

	phdr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (advance && emit),
		.res_in  (res),
		.pop     (m_tready),
		.free    (out_free),
		.valid_q (m_tvalid),
		.res_q   (res_q)
	);

	assign m_tuser = res_q.status;
	assign m_tdata = {7'd0, res_q.new_format, res_q.partial, res_q.length_known,
		res_q.packet_length, res_q.packet_type};

	`PHDR_ASSERT_NOW(a_err_fields_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "error result with nonzero fields")
	`PHDR_ASSERT_NOW(a_partial_new, m_tvalid && m_tdata[39], m_tdata[40] && m_tdata[38], "partial length outside new format")
	`PHDR_ASSERT_NEXT(a_blocked_holds, valid_s1 && emit && m_tvalid && !m_tready, valid_s1 && $stable(byte_s1) && $stable(end_s1), "blocked word left the input register")

endmodule
`default_nettype wire

[dv/tb_pgp_packet_header_parser_core.sv]
// testbench for the packet header parser: byte stream in, checked header results out
module tb_pgp_packet_header_parser_core;
	import phdr_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 12;
	localparam int REPORT_LIMIT = 10;

	// old-format length-of-length codes
	localparam logic [1:0] LL_ONE  = 2'b00;
	localparam logic [1:0] LL_TWO  = 2'b01;
	localparam logic [1:0] LL_FOUR = 2'b10;

	// new-format length encodings
	typedef enum logic [1:0] {
		LEN_ONE,
		LEN_TWO,
		LEN_FIVE,
		LEN_PARTIAL
	} new_len_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	pgp_packet_header_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// parser state mirrored on the testbench side
	phase_t      hdr_phase = PH_IDLE;
	logic [5:0]  hdr_type  = '0;
	logic [31:0] hdr_len   = '0;
	logic [2:0]  hdr_left  = '0;
	logic        hdr_newf  = 1'b0;
	logic [4:0]  hdr_hi5   = '0;

	res_t        expected_headers[$];
	logic [7:0]  hdr_bytes[$];
	int unsigned status_seen[4];
	int unsigned words_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned errors       = 0;
	int unsigned cycle_count  = 0;
	int unsigned burst_left   = 0;
	int unsigned gap_max      = 0;
	bit          hold_req     = 1'b0;
	int unsigned holds_done   = 0;

	// advance the header state by one word; returns 1 when a result is due
	function automatic bit parse_byte(input logic [7:0] b, input logic fin, output res_t r);
		r = '0;
		if (fin) begin
			if (hdr_phase == PH_IDLE)
				r.status = ST_END;
			else
				r.status = ST_TRUNC;
			hdr_phase = PH_IDLE;
			return 1'b1;
		end
		case (hdr_phase)
		PH_OLD_LEN, PH_NEW_FIVE: begin
			hdr_len  = {hdr_len[23:0], b};
			hdr_left = hdr_left - 3'd1;
			if (hdr_left != 3'd0)
				return 1'b0;
			r.packet_type   = hdr_type;
			r.packet_length = hdr_len;
			r.length_known  = 1'b1;
			r.new_format    = hdr_newf;
		end
		PH_NEW_FIRST: begin
			if (b < NEW_ONE_MAX) begin
				r.packet_length = {24'd0, b};
			end else if ((b & TWO_OCT_MASK) == TWO_OCT_CODE) begin
				hdr_hi5   = b[4:0];
				hdr_phase = PH_NEW_SECOND;
				return 1'b0;
			end else if (b == FIVE_OCT_CODE) begin
				hdr_len   = '0;
				hdr_left  = 3'd4;
				hdr_phase = PH_NEW_FIVE;
				return 1'b0;
			end else begin
				r.packet_length = 32'd1 << b[4:0];
				r.partial       = 1'b1;
			end
			r.packet_type  = hdr_type;
			r.length_known = 1'b1;
			r.new_format   = 1'b1;
		end
		PH_NEW_SECOND: begin
			r.packet_type   = hdr_type;
			r.packet_length = {19'd0, hdr_hi5, b} + NEW_TWO_BASE;
			r.length_known  = 1'b1;
			r.new_format    = 1'b1;
		end
		default: begin
			if (b[7:6] == TAG_OLD) begin
				hdr_type = {2'b00, b[5:2]};
				hdr_newf = 1'b0;
				if (b[1:0] == LL_INDET) begin
					r.packet_type = hdr_type;
				end else begin
					hdr_len   = '0;
					hdr_left  = 3'd1 << b[1:0];
					hdr_phase = PH_OLD_LEN;
					return 1'b0;
				end
			end else if (b[7:6] == TAG_NEW) begin
				hdr_type  = b[5:0];
				hdr_newf  = 1'b1;
				hdr_phase = PH_NEW_FIRST;
				return 1'b0;
			end else begin
				r.status = ST_NOT_HDR;
			end
		end
		endcase
		hdr_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic string fmt_res(input res_t r);
		return $sformatf("st=%0d type=%0d len=%h known=%0d part=%0d new=%0d",
			r.status, r.packet_type, r.packet_length, r.length_known, r.partial,
			r.new_format);
	endfunction

	task automatic flag_error(input string what);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("error at %0t: %s", $time, what);
	endtask

	// offer one word; bursts of random length separated by random gaps
	task automatic send_word(input logic [7:0] b, input logic fin);
		res_t        r;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		if (parse_byte(b, fin, r)) begin
			expected_headers.push_back(r);
			status_seen[r.status]++;
		end
	endtask

	task automatic build_header(input bit fmt_new, input logic [5:0] ptype,
		input logic [1:0] kind, input logic [31:0] len);
		int i;
		hdr_bytes.delete();
		if (!fmt_new) begin
			hdr_bytes.push_back({TAG_OLD, ptype[3:0], kind});
			if (kind != LL_INDET)
				for (i = (1 << kind) - 1; i >= 0; i--)
					hdr_bytes.push_back(len[8*i +: 8]);
		end else begin
			hdr_bytes.push_back({TAG_NEW, ptype});
			case (kind)
			LEN_ONE:
				hdr_bytes.push_back(len[7:0]);
			LEN_TWO: begin
				hdr_bytes.push_back(TWO_OCT_CODE | {3'b000, len[12:8]});
				hdr_bytes.push_back(len[7:0]);
			end
			LEN_FIVE: begin
				hdr_bytes.push_back(FIVE_OCT_CODE);
				for (i = 3; i >= 0; i--)
					hdr_bytes.push_back(len[8*i +: 8]);
			end
			default:
				hdr_bytes.push_back(TWO_OCT_MASK | {3'b000, len[4:0]});
			endcase
		end
	endtask

	task automatic send_bytes(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_word(hdr_bytes[i], 1'b0);
	endtask

	task automatic send_header(input bit fmt_new, input logic [5:0] ptype,
		input logic [1:0] kind, input logic [31:0] len);
		build_header(fmt_new, ptype, kind, len);
		send_bytes(hdr_bytes.size());
	endtask

	// mostly well-formed headers with random content, the rest noise, cut headers and stream ends
	task automatic send_random_unit();
		int unsigned pick;
		bit          fmt_new;
		logic [5:0]  ptype;
		logic [1:0]  kind;
		logic [31:0] len;
		pick    = $urandom_range(0, 99);
		fmt_new = 1'($urandom_range(0, 1));
		ptype   = 6'($urandom);
		kind    = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
		0:       len = '0;
		1:       len = '1;
		2:       len = $urandom & 32'hFF;
		default: len = $urandom;
		endcase
		if (fmt_new && kind == LEN_ONE)
			len = len % NEW_ONE_MAX;
		if (fmt_new && kind == LEN_PARTIAL)
			len = $urandom_range(0, 30);
		build_header(fmt_new, ptype, kind, len);
		if (pick < 80) begin
			send_bytes(hdr_bytes.size());
		end else if (pick < 87) begin
			send_word(8'($urandom_range(0, 127)), 1'b0);
		end else if (pick < 92) begin
			send_word(8'($urandom), 1'b0);
		end else if (pick < 97) begin
			if (hdr_bytes.size() > 1)
				send_bytes($urandom_range(1, hdr_bytes.size() - 1));
			send_word(8'($urandom), 1'b1);
		end else begin
			send_word(8'($urandom), 1'b1);
		end
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_headers.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic test_directed();
		gap_max = 2;
		// clean end at a tag boundary, repeated
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		// bytes that are not tags
		send_word(8'h00, 1'b0);
		send_word(8'h7F, 1'b0);
		send_header(1'b0, 6'h0F, LL_ONE, 32'h0000_00FF);
		send_header(1'b0, 6'h00, LL_FOUR, 32'hFFFF_FFFF);
		send_header(1'b0, 6'h00, LL_INDET, '0);
		send_header(1'b1, 6'h3F, LEN_ONE, 32'd191);
		send_header(1'b1, 6'h00, LEN_TWO, 32'h0000_1FFF);
		send_header(1'b1, 6'h15, LEN_FIVE, 32'hFFFF_FFFF);
		send_header(1'b1, 6'h01, LEN_PARTIAL, 32'd30);
		send_header(1'b1, 6'h2A, LEN_PARTIAL, 32'd0);
		// header cut short inside a five-octet length
		build_header(1'b1, 6'h2A, LEN_FIVE, '0);
		send_bytes(3);
		send_word(8'hA5, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_random_stream();
		int unsigned prof;
		int unsigned stop_at;
		for (prof = 0; prof < 3; prof++) begin
			case (prof)
			0:       gap_max = 0;
			1:       gap_max = 4;
			default: gap_max = 12;
			endcase
			stop_at = words_sent + 500;
			while (words_sent < stop_at)
				send_random_unit();
		end
	endtask

	// receiver holds off while single-word results keep coming
	task automatic test_output_stall();
		int unsigned k;
		gap_max  = 0;
		hold_req = 1'b1;
		for (k = 0; k < 80; k++) begin
			if ($urandom_range(0, 1))
				send_header(1'b0, 6'($urandom), LL_INDET, '0);
			else
				send_word(8'($urandom_range(0, 127)), 1'b0);
		end
	endtask

	// short runs, each followed by a pause until every result is back
	task automatic test_drain_pause();
		int unsigned run;
		int unsigned k;
		gap_max = 3;
		for (run = 0; run < 8; run++) begin
			wait_results_drained();
			for (k = $urandom_range(1, 6); k > 0; k--)
				send_random_unit();
		end
		wait_results_drained();
	endtask

	initial begin
		int unsigned ready_pct;
		int unsigned span;
		ready_pct = 100;
		span      = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end
			if (span == 0) begin
				span = $urandom_range(32, 400);
				case ($urandom_range(0, 3))
				0:       ready_pct = 100;
				1:       ready_pct = 80;
				2:       ready_pct = 40;
				default: ready_pct = 10;
				endcase
			end
			span--;
			m_tready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	task automatic check_result();
		res_t want;
		res_t got;
		got.status        = status_t'(m_tuser);
		got.packet_type   = m_tdata[5:0];
		got.packet_length = m_tdata[37:6];
		got.length_known  = m_tdata[38];
		got.partial       = m_tdata[39];
		got.new_format    = m_tdata[40];
		if (expected_headers.size() == 0) begin
			flag_error($sformatf("result with nothing pending: %s", fmt_res(got)));
			return;
		end
		want = expected_headers.pop_front();
		results_seen++;
		if (got.status !== want.status || got.packet_type !== want.packet_type ||
			got.packet_length !== want.packet_length ||
			got.length_known !== want.length_known || got.partial !== want.partial ||
			got.new_format !== want.new_format)
			flag_error($sformatf("result %0d: exp %s / got %s", results_seen,
				fmt_res(want), fmt_res(got)));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results pending", cycle_count,
			expected_headers.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream();
		test_output_stall();
		test_drain_pause();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d words, %0d results checked in %0d cycles, %0d long holds",
			words_sent, results_seen, cycle_count, holds_done);
		$display("  ok %0d, clean end %0d, truncated %0d, not a tag %0d, errors %0d",
			status_seen[ST_OK], status_seen[ST_END], status_seen[ST_TRUNC],
			status_seen[ST_NOT_HDR], errors);
		if (errors == 0 && expected_headers.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
